### src/bdeq_pkg.sv
// Shared constants, codes and types of the bounded double-ended queue.
`default_nettype none
package bdeq_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int ACT_W      = 3;
    localparam int STAT_W     = 2;

    typedef enum logic [ACT_W-1:0] {
        ACT_PUSH_FRONT  = 3'd0,
        ACT_PUSH_BACK   = 3'd1,
        ACT_POP_FRONT   = 3'd2,
        ACT_POP_BACK    = 3'd3,
        ACT_POP_BEFORE  = 3'd4,
        ACT_REVERSE     = 3'd5
    } t_action;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_ONE   = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef struct packed {
        logic                  ins;
        logic                  rem;
        logic [IDX_W-1:0]      pos;
        logic [DATA_WIDTH-1:0] value;
    } t_cell_ctl;

endpackage
`default_nettype wire

### src/bdeq_if.sv
// Valid/ready channel interfaces for queue actions and their results.
`default_nettype none
interface bdeq_req_if;
    import bdeq_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [ACT_W-1:0]      action;
    logic [DATA_WIDTH-1:0] push_value;

    modport source (output valid, output action, output push_value, input ready);
    modport sink   (input valid, input action, input push_value, output ready);
endinterface

interface bdeq_rsp_if;
    import bdeq_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [DATA_WIDTH-1:0] popped_value;
    logic [STAT_W-1:0]     status;
    logic [CNT_W-1:0]      entry_count;

    modport source (output valid, output popped_value, output status,
                    output entry_count, input ready);
    modport sink   (input valid, input popped_value, input status,
                    input entry_count, output ready);
endinterface
`default_nettype wire

### src/bounded_double_ended_queue_core.sv
// Top level of the bounded double-ended queue: control and a row of cells.
// Usage:
//   i_req carries one action per item (push front, push back, pop front,
//   pop back, pop the entry before the back, reverse) with a push word.
//   o_rsp returns one item per action: the popped word (zero when nothing
//   is removed), a status (ok, empty, only one entry, full) and the entry
//   count after the action.
//   Entries live in a row of DEPTH cells in logical order from the low
//   end; an insert or removal updates all cells together by shifting
//   words to a neighbor; a new item may follow each cycle unless o_rsp
//   stalls. The result is registered in the cycle after the item is
//   accepted. Reverse only flips an orientation flag.
//   Reset (i_rst_n low at a clock edge) empties the queue, clears the
//   flag and drops any pending result; cell words are not cleared.
//   While the receiver holds o_rsp.ready low with a result pending,
//   i_req.ready stays low and the queue holds its state.
`default_nettype none
module bounded_double_ended_queue_core (
    input  wire     i_clk,
    input  wire     i_rst_n,
    bdeq_req_if.sink   i_req,
    bdeq_rsp_if.source o_rsp
);
    import bdeq_pkg::*;

    logic [CNT_W-1:0]      r_count;
    logic                  r_rev;
    logic                  r_out_valid;
    logic [DATA_WIDTH-1:0] r_popped;
    logic [STAT_W-1:0]     r_status;
    logic [CNT_W-1:0]      r_count_out;

    logic [CNT_W-1:0]      n_count;
    logic                  n_rev;
    t_status               n_status;
    logic                  take;
    logic                  low_end;
    logic                  full;
    logic                  empty;
    logic [CNT_W-1:0]      cnt_m1;
    logic [CNT_W-1:0]      cnt_m2;
    t_action               act;
    t_cell_ctl             ctl;
    logic [DATA_WIDTH-1:0] tap_or;

    logic [DATA_WIDTH-1:0] w_data  [DEPTH];
    logic [DATA_WIDTH-1:0] w_tap   [DEPTH];
    logic [DATA_WIDTH-1:0] w_below [DEPTH];
    logic [DATA_WIDTH-1:0] w_above [DEPTH];

    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign take        = i_req.valid && i_req.ready;
    assign act         = t_action'(i_req.action);
    assign full        = (r_count == CNT_W'(DEPTH));
    assign empty       = (r_count == '0);
    assign cnt_m1      = CNT_W'(r_count - 1'b1);
    assign cnt_m2      = CNT_W'(r_count - 2'd2);
    assign low_end     = ((act == ACT_PUSH_FRONT) || (act == ACT_POP_FRONT)) != r_rev;

    always_comb begin
        ctl       = '0;
        ctl.value = i_req.push_value;
        n_count   = r_count;
        n_rev     = r_rev;
        n_status  = ST_OK;
        unique case (act)
            ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    ctl.ins = take;
                    ctl.pos = low_end ? '0 : r_count[IDX_W-1:0];
                    n_count = CNT_W'(r_count + 1'b1);
                end
            end
            ACT_POP_FRONT, ACT_POP_BACK: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    ctl.rem = take;
                    ctl.pos = low_end ? '0 : cnt_m1[IDX_W-1:0];
                    n_count = cnt_m1;
                end
            end
            ACT_POP_BEFORE: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else if (r_count == CNT_W'(1)) begin
                    n_status = ST_ONE;
                end else begin
                    ctl.rem = take;
                    ctl.pos = r_rev ? IDX_W'(1) : cnt_m2[IDX_W-1:0];
                    n_count = cnt_m1;
                end
            end
            ACT_REVERSE: begin
                n_rev = !r_rev;
            end
            default: begin
            end
        endcase
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_lo
            assign w_below[g] = '0;
        end else begin : g_lo
            assign w_below[g] = w_data[g-1];
        end
        if (g == DEPTH - 1) begin : g_hi
            assign w_above[g] = '0;
        end else begin : g_hi
            assign w_above[g] = w_data[g+1];
        end
        bdeq_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (ctl),
            .i_index (IDX_W'(g)),
            .i_below (w_below[g]),
            .i_above (w_above[g]),
            .o_data  (w_data[g]),
            .o_tap   (w_tap[g])
        );
    end

    always_comb begin
        tap_or = '0;
        for (int i = 0; i < DEPTH; i++) begin
            tap_or = tap_or | w_tap[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_rev       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                r_count     <= n_count;
                r_rev       <= n_rev;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_popped    <= ctl.rem ? tap_or : '0;
            r_status    <= n_status;
            r_count_out <= n_count;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.popped_value = r_popped;
    assign o_rsp.status       = r_status;
    assign o_rsp.entry_count  = r_count_out;

endmodule
`default_nettype wire

### src/bdeq_cell.sv
// One storage cell of the queue row: inserts, shifts and taps its word.
`default_nettype none
module bdeq_cell (
    input  wire                           i_clk,
    input  wire  bdeq_pkg::t_cell_ctl     i_ctl,
    input  wire  [bdeq_pkg::IDX_W-1:0]    i_index,
    input  wire  [bdeq_pkg::DATA_WIDTH-1:0] i_below,
    input  wire  [bdeq_pkg::DATA_WIDTH-1:0] i_above,
    output logic [bdeq_pkg::DATA_WIDTH-1:0] o_data,
    output logic [bdeq_pkg::DATA_WIDTH-1:0] o_tap
);
    import bdeq_pkg::*;

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;

    always_comb begin
        n_data = r_data;
        if (i_ctl.ins) begin
            if (i_index > i_ctl.pos) begin
                n_data = i_below;
            end else if (i_index == i_ctl.pos) begin
                n_data = i_ctl.value;
            end
        end else if (i_ctl.rem) begin
            if (i_index >= i_ctl.pos) begin
                n_data = i_above;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    assign o_tap  = (i_index == i_ctl.pos) ? r_data : '0;

endmodule
`default_nettype wire

### sim/bdeq_result_checker.sv
// Checker that predicts each queue action and compares the returned items.
`timescale 1ns / 100ps
module bdeq_result_checker
    import bdeq_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    bdeq_req_if   i_req,
    bdeq_rsp_if   i_rsp,
    output int    o_fail_count,
    output int    o_pending_count
);

    typedef struct packed {
        logic [DATA_WIDTH-1:0] popped;
        t_status               status;
        logic [CNT_W-1:0]      count;
    } t_deq_result;

    logic [DATA_WIDTH-1:0] ring_words[$];
    logic                  flipped = 1'b0;
    t_deq_result           due_results[$];
    t_deq_result           want;

    function automatic t_deq_result apply_action(input logic [ACT_W-1:0] act,
                                                 input logic [DATA_WIDTH-1:0] value);
        t_deq_result r;
        int          held;
        r.popped = '0;
        r.status = ST_OK;
        held     = ring_words.size();
        case (act)
            ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
                if (held >= DEPTH) begin
                    r.status = ST_FULL;
                end else if ((act == ACT_PUSH_FRONT) != flipped) begin
                    ring_words = {value, ring_words};
                end else begin
                    ring_words = {ring_words, value};
                end
            end
            ACT_POP_FRONT, ACT_POP_BACK: begin
                if (held == 0) begin
                    r.status = ST_EMPTY;
                end else if ((act == ACT_POP_FRONT) != flipped) begin
                    r.popped = ring_words[0];
                    ring_words.delete(0);
                end else begin
                    r.popped = ring_words[held-1];
                    ring_words.delete(held - 1);
                end
            end
            ACT_POP_BEFORE: begin
                if (held == 0) begin
                    r.status = ST_EMPTY;
                end else if (held == 1) begin
                    r.status = ST_ONE;
                end else if (flipped) begin
                    r.popped = ring_words[1];
                    ring_words.delete(1);
                end else begin
                    r.popped = ring_words[held-2];
                    ring_words.delete(held - 2);
                end
            end
            ACT_REVERSE: begin
                flipped = !flipped;
            end
            default: begin
            end
        endcase
        r.count = CNT_W'(ring_words.size());
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ring_words.delete();
            due_results.delete();
            flipped = 1'b0;
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                if (due_results.size() == 0) begin
                    $error("result item with no action pending");
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = due_results[0];
                    due_results.delete(0);
                    if (i_rsp.popped_value !== want.popped) begin
                        $error("popped_value: expected %h, got %h",
                               want.popped, i_rsp.popped_value);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (i_rsp.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, i_rsp.status);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (i_rsp.entry_count !== want.count) begin
                        $error("entry_count: expected %0d, got %0d",
                               want.count, i_rsp.entry_count);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                due_results = {due_results, apply_action(i_req.action, i_req.push_value)};
            end
        end
        o_pending_count <= due_results.size();
    end

endmodule

### sim/tb_bounded_double_ended_queue_core.sv
// Testbench top: drives queue actions and result stalls, and reports the verdict.
`timescale 1ns / 100ps
module tb_bounded_double_ended_queue_core;
    import bdeq_pkg::*;

    localparam logic [ACT_W-1:0] ACT_SPARE_LO = 3'd6;
    localparam logic [ACT_W-1:0] ACT_SPARE_HI = 3'd7;
    localparam int               RUN_CHUNKS   = 20;
    localparam int               CHUNK_ITEMS  = 35;
    localparam int               DRAIN_CHUNK  = 10;
    localparam longint           TIMEOUT_NS   = 5_000_000;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    int   mismatches;
    int   waiting;
    logic src_calm  = 1'b0;
    logic sink_calm = 1'b0;
    int   stall_left = 0;

    bdeq_req_if req_ch();
    bdeq_rsp_if rsp_ch();

    bounded_double_ended_queue_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    bdeq_result_checker chk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req           (req_ch),
        .i_rsp           (rsp_ch),
        .o_fail_count    (mismatches),
        .o_pending_count (waiting)
    );

    always #5 i_clk = ~i_clk;

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (roll < 60) return 0;
        if (roll < 92) return $urandom_range(3, 1);
        return $urandom_range(30, 8);
    endfunction

    function automatic logic [DATA_WIDTH-1:0] pick_word();
        int roll;
        roll = $urandom_range(9);
        if (roll == 0) return '0;
        if (roll == 1) return '1;
        return $urandom;
    endfunction

    function automatic logic [ACT_W-1:0] pick_action(input int push_pct, input int pop_pct);
        int roll;
        int which;
        roll = $urandom_range(99);
        if (roll < push_pct) begin
            return $urandom_range(1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
        end
        if (roll < push_pct + pop_pct) begin
            which = $urandom_range(2);
            if (which == 0) return ACT_POP_FRONT;
            if (which == 1) return ACT_POP_BACK;
            return ACT_POP_BEFORE;
        end
        if (roll < 97) return ACT_REVERSE;
        return $urandom_range(1) ? ACT_SPARE_HI : ACT_SPARE_LO;
    endfunction

    task automatic send_item(input logic [ACT_W-1:0] act, input logic [DATA_WIDTH-1:0] value);
        int gap;
        gap = src_calm ? 0 : pick_gap();
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.action     <= act;
        req_ch.push_value <= value;
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    task automatic drain_results();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (waiting != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            rsp_ch.ready <= 1'b0;
        end else if (!sink_calm && $urandom_range(99) < 25) begin
            stall_left = pick_gap();
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= 1'b1;
        end
        if ($urandom_range(299) == 0) sink_calm = !sink_calm;
    end

    initial begin
        int chunk;
        int n;
        int push_pct;
        int pop_pct;
        int mode;
        req_ch.valid      <= 1'b0;
        req_ch.action     <= ACT_PUSH_FRONT;
        req_ch.push_value <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_item(ACT_POP_FRONT, 32'h1234_5678);
        send_item(ACT_POP_BACK, '1);
        send_item(ACT_POP_BEFORE, '0);
        send_item(ACT_REVERSE, '1);
        send_item(ACT_REVERSE, '0);
        send_item(ACT_SPARE_LO, '1);
        send_item(ACT_SPARE_HI, 32'h0F0F_0F0F);
        send_item(ACT_PUSH_FRONT, '0);
        send_item(ACT_POP_BEFORE, '1);
        send_item(ACT_PUSH_BACK, '1);
        send_item(ACT_POP_BEFORE, '0);
        send_item(ACT_PUSH_FRONT, 32'hA5A5_A5A5);
        send_item(ACT_PUSH_BACK, 32'h5A5A_5A5A);
        send_item(ACT_REVERSE, '0);
        send_item(ACT_POP_BEFORE, '0);
        send_item(ACT_POP_FRONT, '0);
        send_item(ACT_POP_BACK, '0);
        send_item(ACT_PUSH_FRONT, 32'h0000_0001);
        send_item(ACT_PUSH_BACK, 32'h8000_0000);
        send_item(ACT_REVERSE, '1);
        send_item(ACT_POP_FRONT, '1);
        send_item(ACT_POP_BACK, '1);
        send_item(ACT_POP_BACK, '1);

        for (chunk = 0; chunk < RUN_CHUNKS; chunk++) begin
            mode     = $urandom_range(2);
            src_calm = ($urandom_range(3) == 0);
            push_pct = (mode == 0) ? 70 : (mode == 1) ? 20 : 45;
            pop_pct  = (mode == 0) ? 20 : (mode == 1) ? 70 : 45;
            for (n = 0; n < CHUNK_ITEMS; n++) begin
                send_item(pick_action(push_pct, pop_pct), pick_word());
            end
            if (chunk == DRAIN_CHUNK) drain_results();
        end

        drain_results();
        repeat (5) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("FAIL");
        $finish;
    end

endmodule
